// ----- src/rhsi_pkg.sv -----
// shared types and constants for the rgb to hsi pixel converter
`default_nettype none

package rhsi_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] intensity;
    } t_pix_out;

    localparam int FRAC_W  = 16;
    localparam int DD_W    = 17;
    localparam int ROOT_W  = 24;
    localparam int AN_W    = 9;
    localparam int HQ_W    = 18;
    localparam int SQ_W    = 10;
    localparam int SUM_W   = 10;
    localparam int SNUM_W  = 18;
    localparam int INT_W   = 20;

    localparam logic [8:0]        HUE_FULL   = 9'd360;
    localparam logic [SQ_W-1:0]   SAT_MAX    = 10'd255;
    localparam logic [SNUM_W-1:0] SAT_SCALE  = 18'd765;
    localparam logic [INT_W-1:0]  INT_RECIP  = 20'd683;
    localparam int                INT_SHIFT  = 11;
    localparam logic [7:0]        DEG_MAX    = 8'd180;

    typedef struct packed {
        logic            neg;
        logic [AN_W-1:0] an;
        logic            dd_pos;
        logic [DD_W-1:0] dd;
        logic            bgt;
        logic            zsum;
        logic [7:0]      intensity;
        logic [7:0]      sat;
    } t_ctx;

endpackage

`default_nettype wire

// ----- src/rhsi_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, with side data
`default_nettype none

module rhsi_div_pipe #(
    parameter int NUM_W  = 18,
    parameter int DEN_W  = 10,
    parameter int Q_W    = 10,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [Q_W-1:0]    o_quo,
    output logic [SIDE_W-1:0] o_side
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              r_v    [Q_W];
    logic [RW-1:0]     r_rem  [Q_W];
    logic [DEN_W-1:0]  r_den  [Q_W];
    logic [Q_W-1:0]    r_q    [Q_W];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int K = Q_W - 1 - j;
        logic              c_v;
        logic [RW-1:0]     c_rem;
        logic [DEN_W-1:0]  c_den;
        logic [Q_W-1:0]    c_q;
        logic [SIDE_W-1:0] c_side;
        logic [RW-1:0]     shifted;
        logic [RW-1:0]     n_rem;
        logic [Q_W-1:0]    n_q;

        if (j == 0) begin : g_first
            assign c_v    = i_valid;
            assign c_rem  = RW'(i_num);
            assign c_den  = i_den;
            assign c_q    = '0;
            assign c_side = i_side;
        end else begin : g_next
            assign c_v    = r_v[j-1];
            assign c_rem  = r_rem[j-1];
            assign c_den  = r_den[j-1];
            assign c_q    = r_q[j-1];
            assign c_side = r_side[j-1];
        end

        always_comb begin
            shifted = RW'(c_den) << K;
            n_rem   = c_rem;
            n_q     = c_q;
            if (c_rem >= shifted) begin
                n_rem = c_rem - shifted;
                n_q   = c_q | (Q_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= n_rem;
                r_den[j]  <= c_den;
                r_q[j]    <= n_q;
                r_side[j] <= c_side;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_quo   = r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

`default_nettype wire

// ----- src/rgb_to_hsi_pixel_unit.sv -----
// top level of the rgb to hsi pixel converter
//
// input channel: i_valid / o_ready carry one rgb pixel per beat on i_pix.
// output channel: o_valid / i_ready carry hue, saturation and intensity on o_pix.
// a new pixel may enter every cycle while o_ready is high; sustained throughput
// is one pixel per clock unless the receiver stalls. from input beat to o_valid
// come one setup stage, a 10-stage saturation divider, a 24-stage square root
// (one root bit a stage), an 18-stage hue divider, two index stages, an 8-stage
// binary search over the degree thresholds of the arccos table, and the output
// register. when the receiver stalls, the next finished pixel parks in a skid
// register, and o_ready is low and the whole pipeline holds while it is parked.
// a synchronous active-low reset empties the pipeline and the output side;
// the arccos thresholds are constants, so no fill pass is needed.
// hue of a grey pixel is 0 and saturation of a black pixel is 0.
`default_nettype none

module rgb_to_hsi_pixel_unit
    import rhsi_pkg::*;
#(
    parameter int TABLE_RESOLUTION = 1000
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pix_in  i_pix,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pix_out o_pix
);

    localparam int IDX_MAX = 2 * TABLE_RESOLUTION;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int RES_W   = $clog2(TABLE_RESOLUTION + 1);
    localparam int T_W     = HQ_W + 1;
    localparam int PROD_W  = T_W + RES_W;
    localparam int RAW_W   = PROD_W - FRAC_W;
    localparam int REM_W   = DD_W + 2 * FRAC_W + 1;
    localparam int HNUM_W  = AN_W + 2 * FRAC_W;
    localparam int HDEN_W  = ROOT_W + 1;
    localparam int SRCH_N  = 8;
    localparam int TAB_N   = 256;
    localparam int CTX_W   = $bits(t_ctx);

    typedef logic [IDX_W-1:0] t_thr_tab [TAB_N];

    // highest table index whose cosine still reaches degree d
    function automatic t_thr_tab build_thr();
        t_thr_tab tab;
        real      c;
        for (int d = 0; d < TAB_N; d++) begin
            if (d == 0) begin
                tab[d] = IDX_W'(IDX_MAX);
            end else if (d <= int'(DEG_MAX)) begin
                c = $cos(real'(d) * 3.141592 / 180.0);
                tab[d] = IDX_W'($rtoi(real'(TABLE_RESOLUTION) * (1.0 + c)));
            end else begin
                tab[d] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_thr_tab THR = build_thr();

    localparam logic [T_W-1:0]   T_ONE    = T_W'(1) << FRAC_W;
    localparam logic [RAW_W-1:0] RAW_MAX  = RAW_W'(IDX_MAX);

    logic en;
    logic r_skid_v;
    assign en      = !r_skid_v;
    assign o_ready = en;

    // ---------------- setup stage
    logic signed [10:0] nn;
    logic signed [8:0]  d_rg, d_rb, d_gb;
    logic signed [17:0] p1, p2;
    logic signed [18:0] dd_s;
    logic [SUM_W-1:0]   sum;
    logic [7:0]         mn, mq;
    logic [INT_W-1:0]   ip;
    t_ctx               n_s0_ctx;

    always_comb begin
        nn   = $signed({2'b00, i_pix.red, 1'b0}) - $signed({3'b000, i_pix.green})
             - $signed({3'b000, i_pix.blue});
        d_rg = $signed({1'b0, i_pix.red})   - $signed({1'b0, i_pix.green});
        d_rb = $signed({1'b0, i_pix.red})   - $signed({1'b0, i_pix.blue});
        d_gb = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        p1   = d_rg * d_rg;
        p2   = d_rb * d_gb;
        dd_s = 19'(p1) + 19'(p2);
        sum  = SUM_W'(i_pix.red) + SUM_W'(i_pix.green) + SUM_W'(i_pix.blue);
        mn   = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue < mn) begin
            mn = i_pix.blue;
        end
        mq   = (mn == 8'd0) ? 8'd1 : mn;
        ip   = INT_W'(sum) * INT_RECIP;

        n_s0_ctx.neg       = nn[10];
        n_s0_ctx.an        = nn[10] ? AN_W'(-nn) : AN_W'(nn);
        n_s0_ctx.dd        = dd_s[DD_W-1:0];
        n_s0_ctx.dd_pos    = (dd_s != '0);
        n_s0_ctx.bgt       = (i_pix.blue > i_pix.green);
        n_s0_ctx.zsum      = (sum == '0);
        n_s0_ctx.intensity = ip[INT_SHIFT +: 8];
        n_s0_ctx.sat       = '0;
    end

    logic              r_s0_v;
    t_ctx              r_s0_ctx;
    logic [SNUM_W-1:0] r_s0_snum;
    logic [SUM_W-1:0]  r_s0_sden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ctx  <= n_s0_ctx;
            r_s0_snum <= SNUM_W'(mq) * SAT_SCALE;
            r_s0_sden <= (sum == '0) ? SUM_W'(1) : sum;
        end
    end

    // ---------------- saturation divide
    logic             w_sd_v;
    logic [SQ_W-1:0]  w_sd_q;
    logic [CTX_W-1:0] w_sd_side;

    rhsi_div_pipe #(
        .NUM_W  (SNUM_W),
        .DEN_W  (SUM_W),
        .Q_W    (SQ_W),
        .SIDE_W (CTX_W)
    ) u_sat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_num   (r_s0_snum),
        .i_den   (r_s0_sden),
        .i_side  (r_s0_ctx),
        .o_valid (w_sd_v),
        .o_quo   (w_sd_q),
        .o_side  (w_sd_side)
    );

    t_ctx sd_ctx;
    always_comb begin
        sd_ctx = t_ctx'(w_sd_side);
        if (sd_ctx.zsum || (w_sd_q >= SAT_MAX)) begin
            sd_ctx.sat = '0;
        end else begin
            sd_ctx.sat = 8'(SAT_MAX - w_sd_q);
        end
    end

    // ---------------- square root of dd with 16 fraction bits
    logic              r_sq_v    [ROOT_W];
    logic [REM_W-1:0]  r_sq_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_sq_root [ROOT_W];
    t_ctx              r_sq_ctx  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int K = ROOT_W - 1 - j;
        logic              c_v;
        logic [REM_W-1:0]  c_rem;
        logic [ROOT_W-1:0] c_root;
        t_ctx              c_ctx;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (j == 0) begin : g_first
            assign c_v    = w_sd_v;
            assign c_rem  = REM_W'({sd_ctx.dd, {(2 * FRAC_W){1'b0}}});
            assign c_root = '0;
            assign c_ctx  = sd_ctx;
        end else begin : g_next
            assign c_v    = r_sq_v[j-1];
            assign c_rem  = r_sq_rem[j-1];
            assign c_root = r_sq_root[j-1];
            assign c_ctx  = r_sq_ctx[j-1];
        end

        always_comb begin
            trial  = (REM_W'(c_root) << (K + 1)) + (REM_W'(1) << (2 * K));
            n_rem  = c_rem;
            n_root = c_root;
            if (c_rem >= trial) begin
                n_rem  = c_rem - trial;
                n_root = c_root | (ROOT_W'(1) << K);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (en) begin
                r_sq_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[j]  <= n_rem;
                r_sq_root[j] <= n_root;
                r_sq_ctx[j]  <= c_ctx;
            end
        end
    end

    // ---------------- cosine divide
    t_ctx              sq_ctx;
    logic [HNUM_W-1:0] hd_num;
    logic [HDEN_W-1:0] hd_den;
    assign sq_ctx = r_sq_ctx[ROOT_W-1];
    assign hd_num = {sq_ctx.an, {(2 * FRAC_W){1'b0}}};
    assign hd_den = sq_ctx.dd_pos ? {r_sq_root[ROOT_W-1], 1'b0} : HDEN_W'(1);

    logic             w_hd_v;
    logic [HQ_W-1:0]  w_hd_q;
    logic [CTX_W-1:0] w_hd_side;

    rhsi_div_pipe #(
        .NUM_W  (HNUM_W),
        .DEN_W  (HDEN_W),
        .Q_W    (HQ_W),
        .SIDE_W (CTX_W)
    ) u_hue_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sq_v[ROOT_W-1]),
        .i_num   (hd_num),
        .i_den   (hd_den),
        .i_side  (sq_ctx),
        .o_valid (w_hd_v),
        .o_quo   (w_hd_q),
        .o_side  (w_hd_side)
    );

    // ---------------- offset by one, clamp at zero
    t_ctx           hd_ctx;
    logic [T_W-1:0] n_t;
    assign hd_ctx = t_ctx'(w_hd_side);

    always_comb begin
        if (!hd_ctx.neg) begin
            n_t = T_ONE + T_W'(w_hd_q);
        end else if (T_W'(w_hd_q) >= T_ONE) begin
            n_t = '0;
        end else begin
            n_t = T_ONE - T_W'(w_hd_q);
        end
    end

    logic           r_t_v;
    logic [T_W-1:0] r_t;
    t_ctx           r_t_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v <= 1'b0;
        end else if (en) begin
            r_t_v <= w_hd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t     <= n_t;
            r_t_ctx <= hd_ctx;
        end
    end

    // ---------------- table index
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw;
    logic [IDX_W-1:0]  n_idx;

    always_comb begin
        prod  = PROD_W'(r_t) * PROD_W'(TABLE_RESOLUTION);
        raw   = prod[PROD_W-1:FRAC_W];
        n_idx = (raw > RAW_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(raw);
    end

    logic             r_i_v;
    logic [IDX_W-1:0] r_idx;
    t_ctx             r_i_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (en) begin
            r_i_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx   <= n_idx;
            r_i_ctx <= r_t_ctx;
        end
    end

    // ---------------- binary search for the largest degree still reached
    logic             r_s_v   [SRCH_N];
    logic [7:0]       r_s_d   [SRCH_N];
    logic [IDX_W-1:0] r_s_idx [SRCH_N];
    t_ctx             r_s_ctx [SRCH_N];

    for (genvar j = 0; j < SRCH_N; j++) begin : g_srch
        localparam int B = SRCH_N - 1 - j;
        logic             c_v;
        logic [7:0]       c_d;
        logic [IDX_W-1:0] c_idx;
        t_ctx             c_ctx;
        logic [7:0]       cand;
        logic [7:0]       n_d;

        if (j == 0) begin : g_first
            assign c_v   = r_i_v;
            assign c_d   = '0;
            assign c_idx = r_idx;
            assign c_ctx = r_i_ctx;
        end else begin : g_next
            assign c_v   = r_s_v[j-1];
            assign c_d   = r_s_d[j-1];
            assign c_idx = r_s_idx[j-1];
            assign c_ctx = r_s_ctx[j-1];
        end

        always_comb begin
            cand = c_d | (8'(1) << B);
            n_d  = c_d;
            if ((cand <= DEG_MAX) && (THR[cand] >= c_idx)) begin
                n_d = cand;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_v[j] <= 1'b0;
            end else if (en) begin
                r_s_v[j] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_d[j]   <= n_d;
                r_s_idx[j] <= c_idx;
                r_s_ctx[j] <= c_ctx;
            end
        end
    end

    // ---------------- result assembly and output side
    t_ctx       fin_ctx;
    logic [7:0] theta;
    t_pix_out   pipe_pix;
    logic       pipe_v;

    always_comb begin
        fin_ctx = r_s_ctx[SRCH_N-1];
        theta   = fin_ctx.dd_pos ? r_s_d[SRCH_N-1] : 8'd0;
        pipe_pix.hue        = fin_ctx.bgt ? (HUE_FULL - 9'(theta)) : 9'(theta);
        pipe_pix.saturation = fin_ctx.sat;
        pipe_pix.intensity  = fin_ctx.intensity;
        pipe_v  = r_s_v[SRCH_N-1];
    end

    logic     r_out_v;
    t_pix_out r_out;
    t_pix_out r_skid;
    logic     n_out_v;
    logic     n_skid_v;
    logic     out_load;
    logic     skid_load;
    logic     from_skid;

    always_comb begin
        n_out_v   = r_out_v;
        n_skid_v  = r_skid_v;
        out_load  = 1'b0;
        skid_load = 1'b0;
        from_skid = 1'b0;
        if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                n_out_v   = 1'b1;
                n_skid_v  = 1'b0;
                out_load  = 1'b1;
                from_skid = 1'b1;
            end else begin
                n_out_v  = pipe_v && en;
                out_load = 1'b1;
            end
        end else if (pipe_v && en) begin
            // output is stalled, park the beat
            n_skid_v  = 1'b1;
            skid_load = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= from_skid ? r_skid : pipe_pix;
        end
        if (skid_load) begin
            r_skid <= pipe_pix;
        end
    end

    assign o_valid = r_out_v;
    assign o_pix   = r_out;

endmodule

`default_nettype wire

// ----- src/rhsi_checker.sv -----
// port-level checks for the rgb to hsi pixel converter, bound to the top level
`default_nettype none

module rhsi_checker
    import rhsi_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_ready,
    input logic     o_valid,
    input logic     i_ready,
    input t_pix_out o_pix
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pix))
        else $error("output beat changed while stalled");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pix.hue <= HUE_FULL)
        else $error("hue out of range");

    // input side closes only when a result is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("input ready fell without an output stall");

endmodule

bind rgb_to_hsi_pixel_unit rhsi_checker u_rhsi_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the rgb to hsi pixel converter
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import rhsi_pkg::*;

    localparam int TABLE_RES = 1000;
    localparam int ACOS_LEN  = 2 * TABLE_RES + 1;
    localparam int IDLE_LIMIT = 4000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_pix_in  i_pix;
    logic     o_valid;
    logic     i_ready;
    t_pix_out o_pix;

    rgb_to_hsi_pixel_unit #(.TABLE_RESOLUTION(TABLE_RES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pix   (o_pix)
    );

    logic [7:0] acos_deg [ACOS_LEN];
    t_pix_out   pending_hsi [$];
    int         err_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         hold_len;
    bit         hold_req;
    int         quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- arccos table, 60 fraction bits ----------------
    function automatic logic [63:0] frac60_div(logic [63:0] num, logic [63:0] den);
        logic [127:0] wide;
        wide = {64'd0, num} << 60;
        return 64'(wide / {64'd0, den});
    endfunction

    function automatic logic [63:0] frac60_mul(logic [63:0] x, logic [63:0] y);
        logic [127:0] wide;
        wide = {64'd0, x} * {64'd0, y};
        return 64'(wide >> 60);
    endfunction

    function automatic longint cos_of_deg(int unsigned d);
        logic [63:0] ang, ang2, term, acc;
        ang  = frac60_div(64'(d) * 64'd392699, 64'd22500000);
        ang2 = frac60_mul(ang, ang);
        term = 64'd1 << 60;
        acc  = 64'd1 << 60;
        for (int k = 1; k <= 30; k++) begin
            term = frac60_mul(term / 64'((2 * k - 1) * (2 * k)), ang2);
            if (k % 2 == 1) acc = acc - term;
            else acc = acc + term;
        end
        return longint'(acc);
    endfunction

    initial begin
        longint cs [181];
        longint x;
        int d;
        for (int k = 0; k <= 180; k++) cs[k] = cos_of_deg(k);
        for (int i = 0; i < ACOS_LEN; i++) begin
            x = longint'(frac60_div(64'(i), 64'(TABLE_RES))) - (longint'(1) <<< 60);
            d = 180;
            while (d > 0 && x > cs[d]) d--;
            acos_deg[i] = 8'(d);
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_pix_out convert_pixel(t_pix_in p);
        int r, g, b, n, dd, theta, sum, mn, quo;
        longint t;
        logic [63:0] root, mag, idx;
        t_pix_out res;
        r = p.red;
        g = p.green;
        b = p.blue;
        n = 2 * r - g - b;
        dd = (r - g) * (r - g) + (r - b) * (g - b);
        theta = 0;
        if (dd > 0) begin
            root = int_sqrt(64'(dd) << 32);
            mag  = (64'(n < 0 ? -n : n) << 32) / (2 * root);
            t    = 65536 + (n < 0 ? -longint'(mag) : longint'(mag));
            if (t < 0) t = 0;
            idx = (64'(t) * TABLE_RES) >> 16;
            if (idx > 2 * TABLE_RES) idx = 2 * TABLE_RES;
            theta = acos_deg[idx];
        end
        res.hue = 9'((b <= g) ? theta : 360 - theta);
        sum = r + g + b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        if (mn == 0) mn = 1;
        if (sum == 0) begin
            res.saturation = 8'd0;
        end else begin
            quo = 765 * mn / sum;
            res.saturation = 8'((quo >= 255) ? 0 : 255 - quo);
        end
        res.intensity = 8'(sum / 3);
        return res;
    endfunction

    // ---------------- scoreboard and watchdog ----------------
    always @(posedge i_clk) begin
        t_pix_out want;
        if (i_rst_n) begin
            if (i_valid && o_ready) pending_hsi.push_back(convert_pixel(i_pix));
            if (o_valid && i_ready) begin
                if (pending_hsi.size() == 0) begin
                    $display("%0t: unexpected beat hue=%0d sat=%0d int=%0d", $time,
                             o_pix.hue, o_pix.saturation, o_pix.intensity);
                    err_count++;
                end else begin
                    want = pending_hsi.pop_front();
                    if (want.hue !== o_pix.hue) begin
                        $display("%0t: hue expected %0d actual %0d", $time,
                                 want.hue, o_pix.hue);
                        err_count++;
                    end
                    if (want.saturation !== o_pix.saturation) begin
                        $display("%0t: saturation expected %0d actual %0d", $time,
                                 want.saturation, o_pix.saturation);
                        err_count++;
                    end
                    if (want.intensity !== o_pix.intensity) begin
                        $display("%0t: intensity expected %0d actual %0d", $time,
                                 want.intensity, o_pix.intensity);
                        err_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("rgb_to_hsi_pixel_unit verification failed");
                $finish;
            end
        end
    end

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        int hold_left;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (hold_req) begin
                hold_left = hold_len;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        i_valid <= 1'b1;
        i_pix   <= '{red: r, green: g, blue: b};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    task automatic pause_sender();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_pixel();
        logic [7:0] base;
        case ($urandom_range(9))
            0: begin
                // near grey, small differences stress the root and index clamp
                base = 8'($urandom);
                send_pixel(base, 8'(base + $urandom_range(2)),
                           8'(base - $urandom_range(2)));
            end
            1: send_pixel(8'($urandom_range(3)), 8'($urandom_range(3)),
                          8'($urandom_range(3)));
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd200, 8'd201, 8'd200);
        send_pixel(8'd200, 8'd199, 8'd200);
        send_pixel(8'd10,  8'd10,  8'd11);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd85,  8'd0,   8'd170);
        pause_sender();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) random_pixel();
        pause_sender();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        hold_req = 1'b1;
        repeat (120) random_pixel();
        pause_sender();
    endtask

    initial begin
        int drain;
        err_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pix   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0, 320);
        test_random(48, 0, 320);
        test_random(0, 48, 320);
        test_random(15, 15, 320);
        test_backpressure();
        test_random(0, 0, 60);

        drain = 0;
        while (pending_hsi.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && pending_hsi.size() == 0) begin
            $display("rgb_to_hsi_pixel_unit verification clean");
        end else begin
            $display("rgb_to_hsi_pixel_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
